// ----- hdl/cesa_pkg.sv -----
// ============================================================================
// cesa_pkg - CBOR encoded size accumulator package
// Beat payload types, item kind codes and internal control structs.
// ============================================================================
package cesa_pkg;

    // Item kind codes; the remaining codes are unsupported
    localparam logic [3:0] KIND_ARRAY  = 4'd0;
    localparam logic [3:0] KIND_MAP    = 4'd1;
    localparam logic [3:0] KIND_TEXT   = 4'd2;
    localparam logic [3:0] KIND_BYTES  = 4'd3;
    localparam logic [3:0] KIND_FALSE  = 4'd4;
    localparam logic [3:0] KIND_TRUE   = 4'd5;
    localparam logic [3:0] KIND_NULL   = 4'd6;
    localparam logic [3:0] KIND_UNDEF  = 4'd7;
    localparam logic [3:0] KIND_TAG    = 4'd8;
    localparam logic [3:0] KIND_UINT   = 4'd9;
    localparam logic [3:0] KIND_SIMPLE = 4'd10;
    localparam logic [3:0] KIND_NEGINT = 4'd11;
    localparam logic [3:0] KIND_DOUBLE = 4'd12;

    // Largest per-item contribution: 5-byte head plus a 32-bit string length
    localparam int ADD_W = 33;

    typedef struct packed {
        logic [3:0]  item_kind;
        logic [31:0] item_length;
        logic [63:0] item_value;
        logic        indefinite;
        logic        last_item;
    } item_t;

    typedef struct packed {
        logic [31:0] total_bytes;
        logic        failed;
    } result_t;

    typedef struct packed {
        logic [ADD_W-1:0] add_bytes;
        logic             bad_kind;
    } item_size_t;

    typedef struct packed {
        logic step;
        logic indefinite;
        logic last_item;
    } acc_ctrl_t;

endpackage

// ----- hdl/cesa_item_size.sv -----
// ============================================================================
// cesa_item_size - encoded size of one CBOR data item
// Head size from the argument, string payload, and double narrowing check.
// ============================================================================
module cesa_item_size (
    input  cesa_pkg::item_t      item,
    output cesa_pkg::item_size_t size
);

    function automatic logic [3:0] head_size(input logic [63:0] arg);
        if (arg < 64'd24) begin
            return 4'd1;
        end else if (arg < 64'd256) begin
            return 4'd2;
        end else if (arg < 64'd65536) begin
            return 4'd3;
        end else if (arg[63:32] == 32'd0) begin
            return 4'd5;
        end else begin
            return 4'd9;
        end
    endfunction

    // Shortest IEEE form (half 3, float 5, double 9) that holds the value exactly
    function automatic logic [3:0] double_size(input logic [63:0] v);
        logic [10:0] e;
        logic [51:0] m;
        logic [5:0]  sh;
        logic [51:0] mask;
        logic [3:0]  r;
        e    = v[62:52];
        m    = v[51:0];
        sh   = 6'd0;
        mask = 52'd0;
        if (e == 11'h7FF) begin
            r = 4'd3;                                   // NaN or infinity
        end else if (e == 11'd0) begin
            r = (m == 52'd0) ? 4'd3 : 4'd9;             // zero, or subnormal
        end else if (e > 11'd1150) begin
            r = 4'd9;                                   // beyond float range
        end else if (e >= 11'd897) begin
            // float normal: low 29 mantissa bits must be clear
            if (m[28:0] != 29'd0) begin
                r = 4'd9;
            end else if (e inside {[11'd1009:11'd1038]}) begin
                r = (m[41:29] == 13'd0) ? 4'd3 : 4'd5;  // half normal range
            end else if (e inside {[11'd999:11'd1008]}) begin
                // half subnormal: more low bits must be clear
                sh   = 6'(11'd1051 - e);
                mask = ~({52{1'b1}} << sh);
                r    = ((m & mask) == 52'd0) ? 4'd3 : 4'd5;
            end else begin
                r = 4'd5;
            end
        end else if (e >= 11'd874) begin
            // float subnormal: shifted-out bits must be clear
            sh   = 6'(11'd926 - e);
            mask = ~({52{1'b1}} << sh);
            r    = ((m & mask) == 52'd0) ? 4'd5 : 4'd9;
        end else begin
            r = 4'd9;
        end
        return r;
    endfunction

    always_comb begin
        size.add_bytes = '0;
        size.bad_kind  = 1'b0;
        case (item.item_kind)
            cesa_pkg::KIND_ARRAY: begin
                size.add_bytes = cesa_pkg::ADD_W'(head_size({32'd0, item.item_length}));
            end
            cesa_pkg::KIND_MAP: begin
                // head counts pairs
                size.add_bytes =
                    cesa_pkg::ADD_W'(head_size({33'd0, item.item_length[31:1]}));
            end
            cesa_pkg::KIND_TEXT, cesa_pkg::KIND_BYTES: begin
                size.add_bytes =
                    cesa_pkg::ADD_W'(head_size({32'd0, item.item_length}))
                    + {1'b0, item.item_length};
            end
            cesa_pkg::KIND_FALSE, cesa_pkg::KIND_TRUE,
            cesa_pkg::KIND_NULL, cesa_pkg::KIND_UNDEF: begin
                size.add_bytes = cesa_pkg::ADD_W'(1);
            end
            cesa_pkg::KIND_TAG, cesa_pkg::KIND_UINT, cesa_pkg::KIND_SIMPLE: begin
                size.add_bytes = cesa_pkg::ADD_W'(head_size(item.item_value));
            end
            cesa_pkg::KIND_NEGINT: begin
                size.add_bytes = cesa_pkg::ADD_W'(head_size(~item.item_value));
            end
            cesa_pkg::KIND_DOUBLE: begin
                size.add_bytes = cesa_pkg::ADD_W'(double_size(item.item_value));
            end
            default: begin
                size.bad_kind = 1'b1;
            end
        endcase
    end

endmodule

// ----- hdl/cesa_accum.sv -----
// ============================================================================
// cesa_accum - saturating byte total, sticky error and result register
// Adds one definite-length item per step; a last item loads the result and clears the sum.
// ============================================================================
module cesa_accum (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cesa_pkg::acc_ctrl_t  ctrl,
    input  cesa_pkg::item_size_t size,
    output logic                 out_free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cesa_pkg::result_t    m_result
);

    logic [31:0]       total_reg;
    logic [31:0]       total_next;
    logic              err_reg;
    logic              err_next;
    logic              m_valid_reg;
    cesa_pkg::result_t result_reg;
    logic [33:0]       sum;

    assign sum = {2'b00, total_reg} + {1'b0, size.add_bytes};

    always_comb begin
        total_next = total_reg;
        err_next   = err_reg;
        if (!ctrl.indefinite) begin
            total_next = (sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum[31:0];
            err_next   = err_reg | size.bad_kind;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctrl.step && ctrl.last_item) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (ctrl.step) begin
                if (ctrl.last_item) begin
                    total_reg <= '0;
                    err_reg   <= 1'b0;
                end else begin
                    total_reg <= total_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.step && ctrl.last_item) begin
            result_reg.total_bytes <= err_next ? 32'd0 : total_next;
            result_reg.failed      <= err_next;
        end
    end

endmodule

// ----- hdl/cbor_encoded_size_accumulator.sv -----
// ============================================================================
// cbor_encoded_size_accumulator - CBOR preferred-serialization size counter
// Sums the encoded byte count of a preorder stream of CBOR data items.
// ============================================================================
// Usage:
//   Input channel (s_valid / s_ready / s_item): one CBOR data item per beat,
//   in preorder. Indefinite-length items add nothing. The beat with
//   last_item set closes the sequence.
//   Result channel (m_valid / m_ready / m_result): one beat per sequence,
//   carrying the saturated byte total (0 on error) and the failed flag,
//   which is set when an unsupported kind was seen in a definite-length item.
//   Throughput: one item per cycle while no last item waits on a stalled result. The only state carried from
//   item to item is the 32-bit saturating total and the sticky error flag,
//   updated by one add in the accumulator stage.
//   Path: an item is held in the input register; a last item leaving it
//   loads its result into the result register, which drives the result
//   channel.
//   Reset (aresetn low, synchronous): clears the total, the error flag and
//   both valid flags; s_ready is high as soon as reset is released.
//   Stall: while a result waits for m_ready, non-last items keep flowing.
//   A following last item holds in the input register, and s_ready drops
//   only then, until the waiting result is taken.
// ============================================================================
module cbor_encoded_size_accumulator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cesa_pkg::item_t     s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output cesa_pkg::result_t   m_result
);

    logic                 in_valid_reg;
    cesa_pkg::item_t      in_item_reg;
    cesa_pkg::item_size_t item_size;
    cesa_pkg::acc_ctrl_t  acc_ctrl;
    logic                 out_free;
    logic                 advance;

    // Advance the held item unless it is a last item facing a full result slot
    assign advance = in_valid_reg && (!in_item_reg.last_item || out_free);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Payload: load on every accepted beat
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    cesa_item_size u_item_size (
        .item (in_item_reg),
        .size (item_size)
    );

    assign acc_ctrl.step       = advance;
    assign acc_ctrl.indefinite = in_item_reg.indefinite;
    assign acc_ctrl.last_item  = in_item_reg.last_item;

    cesa_accum u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (acc_ctrl),
        .size     (item_size),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

endmodule

// ----- hdl/cesa_checker.sv -----
// ============================================================================
// cesa_checker - port-level checks for the size accumulator
// Watches the handshakes and result fields of the top level.
// ============================================================================
module cesa_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input cesa_pkg::result_t m_result
);

    // Drop any pending result on reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Hold a stalled result beat
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("stalled result changed");

    // A failed sequence reports zero bytes
    a_failed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.failed |-> m_result.total_bytes == 32'd0)
        else $error("failed result with nonzero total");

    // Backpressure on input only while a result stalls
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a stalled result");

endmodule

bind cbor_encoded_size_accumulator cesa_checker u_cesa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);
